// ===== hw/rtl/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg: shared types and constants for the nearest tile snap block
// Field widths that the stream format fixes and the item opcodes.
// ----------------------------------------------------------------------------
package nts_pkg;

   // fixed field widths of the item format
   localparam int SLOT_W = 10;
   localparam int DIST_W = 50;
   localparam int CNT_W  = 11;

   // item opcodes carried in req_tuser
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

endpackage

// ===== hw/rtl/nearest_tile_snap.sv =====
// ----------------------------------------------------------------------------
// nearest_tile_snap: nearest stored tile center to a query point
// Holds a table of 3D tile centers and returns the closest one to a query.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: an item with tuser = write stores (x, y, z) at the slot
//   and gives no result. An item with tuser = query scans slots
//   0 to tile_count-1 (clamped to MAX_TILES) through one shared datapath
//   (table read, coordinate subtract, square, sum, compare) at one slot per
//   cycle; the lower slot wins a tie.
//   rsp channel: one item per query with the nearest center, its slot and
//   squared distance; an empty table returns the query point, found clear.
//   A query passes the one read port of the table and the five stage scan
//   datapath on its way to the result register; an empty table skips the
//   scan and goes straight to the done state.
//   req_tready is high only while no query is in progress. A finished result
//   waits in the output register while the next item is taken; a later query
//   holds its result in the done state until the register is free.
//   csr_wr_en writes tile_count; write it only while the block is idle.
//   Reset clears control state and tile_count; the table is not cleared and
//   every slot that a query scans must have been written since reset.
// ----------------------------------------------------------------------------
module nearest_tile_snap #(
   parameter int MAX_TILES  = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [nts_pkg::CNT_W-1:0]    csr_wr_data,   // tile_count
   // request stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // slot, pos_x, pos_y, pos_z (low to high), zero padded
   input  logic [((nts_pkg::SLOT_W + 3*COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                         req_tuser,     // opcode
   // response stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // snap_x, snap_y, snap_z, nearest_slot, nearest_dist_sq (low to high)
   output logic [((3*COORD_BITS + nts_pkg::SLOT_W + nts_pkg::DIST_W + 7) / 8) * 8 - 1:0]
                                        rsp_tdata,
   output logic                         rsp_tuser      // tile_found
);

   localparam int CB     = COORD_BITS;
   localparam int SLOT_W = nts_pkg::SLOT_W;
   localparam int DIST_W = nts_pkg::DIST_W;
   localparam int CNT_W  = nts_pkg::CNT_W;
   localparam int RSP_W  = ((3*CB + SLOT_W + DIST_W + 7) / 8) * 8;
   localparam int IW     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int NW     = $clog2(MAX_TILES + 1);
   localparam int SQ_W   = 2*CB + 2;
   localparam int SW     = 2*CB + 4;
   localparam int DW     = (SW > 64) ? 64 : SW;
   localparam int PT_W   = 3*CB;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff;

   // request fields
   logic [SLOT_W-1:0]   req_slot;
   logic [CB-1:0]       req_x, req_y, req_z;
   logic                req_acc;
   logic                wr_acc;
   logic                qry_acc;
   logic [NW-1:0]       cnt_clamp;

   assign req_slot = req_tdata[0 +: SLOT_W];
   assign req_x    = req_tdata[SLOT_W +: CB];
   assign req_y    = req_tdata[SLOT_W + CB +: CB];
   assign req_z    = req_tdata[SLOT_W + 2*CB +: CB];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc  = req_tvalid && req_tready;
   assign wr_acc   = req_acc && (req_tuser == nts_pkg::OP_WRITE);
   assign qry_acc  = req_acc && (req_tuser == nts_pkg::OP_QUERY);

   // configuration register
   logic [CNT_W-1:0] tile_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_count_ff <= '0;
      end else if (csr_wr_en) begin
         tile_count_ff <= csr_wr_data;
      end
   end

   // clamp the scan length to the table depth
   always_comb begin
      if (32'(tile_count_ff) > MAX_TILES) begin
         cnt_clamp = NW'(MAX_TILES);
      end else begin
         cnt_clamp = NW'(tile_count_ff);
      end
   end

   // tile table with one write port and one registered read port
   logic [PT_W-1:0] tile_mem_ff [MAX_TILES];
   logic [PT_W-1:0] rd_data_ff;
   logic [IW-1:0]   addr_ff;
   logic            issue;
   logic            issue_last;
   logic [IW-1:0]   last_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_acc && (32'(req_slot) < MAX_TILES)) begin
         tile_mem_ff[IW'(req_slot)] <= {req_z, req_y, req_x};
      end
      rd_data_ff <= tile_mem_ff[addr_ff];
   end

   assign issue      = (state_ff == ST_SCAN);
   assign issue_last = issue && (addr_ff == last_addr_ff);

   // query point held for the whole scan
   logic [CB-1:0] q_x_ff, q_y_ff, q_z_ff;

   // stage 1: table read data
   logic          p1_vld_ff, p1_last_ff;
   logic [IW-1:0] p1_idx_ff;

   // stage 2: coordinate differences
   logic                 p2_vld_ff, p2_last_ff;
   logic [IW-1:0]        p2_idx_ff;
   logic [PT_W-1:0]      p2_pt_ff;
   logic signed [CB:0]   dx_ff, dy_ff, dz_ff;

   // stage 3: squares
   logic                 p3_vld_ff, p3_last_ff;
   logic [IW-1:0]        p3_idx_ff;
   logic [PT_W-1:0]      p3_pt_ff;
   logic [SQ_W-1:0]      sqx_ff, sqy_ff, sqz_ff;
   logic [SQ_W-1:0]      sqx_in, sqy_in, sqz_in;

   // stage 4: summed distance
   logic                 p4_vld_ff, p4_last_ff;
   logic [IW-1:0]        p4_idx_ff;
   logic [PT_W-1:0]      p4_pt_ff;
   logic [DW-1:0]        dist_ff;
   logic [SW-1:0]        sum_in;
   logic [DW-1:0]        dist_in;

   logic [CB-1:0] t_x, t_y, t_z;
   assign t_x = rd_data_ff[0 +: CB];
   assign t_y = rd_data_ff[CB +: CB];
   assign t_z = rd_data_ff[2*CB +: CB];

   assign sqx_in = dx_ff * dx_ff;
   assign sqy_in = dy_ff * dy_ff;
   assign sqz_in = dz_ff * dz_ff;
   assign sum_in = SW'(sqx_ff) + SW'(sqy_ff) + SW'(sqz_ff);

   // saturate at 64 bits where the sum can grow past it
   generate
      if (SW > DW) begin : g_sat
         assign dist_in = (|sum_in[SW-1:DW]) ? '1 : sum_in[DW-1:0];
      end else begin : g_nosat
         assign dist_in = DW'(sum_in);
      end
   endgenerate

   // scan datapath valid and last flags
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         p4_vld_ff  <= 1'b0;
         p1_last_ff <= 1'b0;
         p2_last_ff <= 1'b0;
         p3_last_ff <= 1'b0;
         p4_last_ff <= 1'b0;
      end else begin
         p1_vld_ff  <= issue;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         p4_vld_ff  <= p3_vld_ff;
         p1_last_ff <= issue_last;
         p2_last_ff <= p1_last_ff;
         p3_last_ff <= p2_last_ff;
         p4_last_ff <= p3_last_ff;
      end
   end

   // scan datapath payload
   always_ff @(posedge clock) begin
      p1_idx_ff <= addr_ff;
      p2_idx_ff <= p1_idx_ff;
      p2_pt_ff  <= rd_data_ff;
      dx_ff     <= $signed({q_x_ff[CB-1], q_x_ff}) - $signed({t_x[CB-1], t_x});
      dy_ff     <= $signed({q_y_ff[CB-1], q_y_ff}) - $signed({t_y[CB-1], t_y});
      dz_ff     <= $signed({q_z_ff[CB-1], q_z_ff}) - $signed({t_z[CB-1], t_z});
      p3_idx_ff <= p2_idx_ff;
      p3_pt_ff  <= p2_pt_ff;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      sqz_ff    <= sqz_in;
      p4_idx_ff <= p3_idx_ff;
      p4_pt_ff  <= p3_pt_ff;
      dist_ff   <= dist_in;
   end

   // best candidate so far
   logic            found_ff;
   logic [IW-1:0]   best_idx_ff;
   logic [DW-1:0]   best_dist_ff;
   logic [PT_W-1:0] best_pt_ff;
   logic            take_best;

   assign take_best = p4_vld_ff && (!found_ff || (dist_ff < best_dist_ff));

   // output register
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_user_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // sequencer, scan state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         addr_ff      <= '0;
      end else begin
         // the done state refills the register itself
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take_best) begin
            found_ff     <= 1'b1;
            best_idx_ff  <= p4_idx_ff;
            best_dist_ff <= dist_ff;
            best_pt_ff   <= p4_pt_ff;
         end
         case (state_ff)
            ST_IDLE: begin
               addr_ff <= '0;
               if (qry_acc) begin
                  q_x_ff       <= req_x;
                  q_y_ff       <= req_y;
                  q_z_ff       <= req_z;
                  found_ff     <= 1'b0;
                  best_idx_ff  <= '0;
                  best_dist_ff <= '0;
                  best_pt_ff   <= {req_z, req_y, req_x};
                  last_addr_ff <= IW'(cnt_clamp - NW'(1));
                  if (cnt_clamp == '0) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               addr_ff <= addr_ff + IW'(1);
               if (issue_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (p4_vld_ff && p4_last_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= found_ff;
                  rsp_data_ff  <= RSP_W'({DIST_W'(best_dist_ff), SLOT_W'(best_idx_ff),
                                          best_pt_ff});
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== dv/nearest_tile_snap_tb.sv =====
// ----------------------------------------------------------------------------
// nearest_tile_snap_tb: self-checking bench for the nearest tile snap block
// Drives write and query items on the request stream and checks each
// response against a behavioral nearest-center search over a mirrored copy
// of the tile table and the tile_count register. A short directed part runs
// first, then the low slots of the table are filled, then randomized phases
// with various tile counts and flow-control pressure on both streams.
// ----------------------------------------------------------------------------
module nearest_tile_snap_tb;

   localparam int SLOT_W        = nts_pkg::SLOT_W;
   localparam int DIST_W        = nts_pkg::DIST_W;
   localparam int CNT_W         = nts_pkg::CNT_W;
   localparam int COORD_W       = 24;
   localparam int TILES         = 1024;
   localparam int FILL_SLOTS    = 112;
   localparam int PHASE_ITEMS   = 32;
   localparam int REQ_W         = ((SLOT_W + 3*COORD_W + 7) / 8) * 8;
   localparam int RSP_W         = ((3*COORD_W + SLOT_W + DIST_W + 7) / 8) * 8;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 1100;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = 24'h7FFFFF;
   localparam coord_type COORD_MIN = 24'h800000;

   typedef struct packed {
      nts_pkg::opcode_type op;
      logic [SLOT_W-1:0]   slot;
      coord_type           x;
      coord_type           y;
      coord_type           z;
   } tile_item_type;

   typedef struct packed {
      coord_type         x;
      coord_type         y;
      coord_type         z;
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [DIST_W-1:0] dist_sq;
   } snap_result_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]  csr_wr_data = '0;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata   = '0;   // slot, pos_x, pos_y, pos_z
   logic              req_tuser   = 1'b0; // opcode
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;          // snap_x, snap_y, snap_z, slot, dist
   logic              rsp_tuser;          // tile_found

   // mirrored block state
   coord_type         mirror_x [TILES];
   coord_type         mirror_y [TILES];
   coord_type         mirror_z [TILES];
   int unsigned       mirror_count = 0;

   // stimulus side copy of the table, used to aim queries at stored centers
   coord_type         plan_x [TILES];
   coord_type         plan_y [TILES];
   coord_type         plan_z [TILES];

   tile_item_type     pending_items [$];
   snap_result_type   snap_expected [$];
   tile_item_type     in_flight;
   snap_result_type   seen_snap;
   snap_result_type   due_snap;

   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                mismatch_count = 0;
   int                results_seen = 0;
   int                quiet_cycles = 0;

   nearest_tile_snap uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // nearest center over the scanned slots, lower slot wins a tie
   function automatic snap_result_type nearest_tile(tile_item_type q);
      snap_result_type r;
      int unsigned     span;
      int unsigned     i;
      longint          dx, dy, dz, d, best;
      r.x = q.x;
      r.y = q.y;
      r.z = q.z;
      r.found = 1'b0;
      r.slot = '0;
      best = 0;
      span = (mirror_count > TILES) ? TILES : mirror_count;
      for (i = 0; i < span; i++) begin
         dx = longint'(q.x) - longint'(mirror_x[i]);
         dy = longint'(q.y) - longint'(mirror_y[i]);
         dz = longint'(q.z) - longint'(mirror_z[i]);
         d = dx*dx + dy*dy + dz*dz;
         if (!r.found || d < best) begin
            r.found = 1'b1;
            r.slot = i[SLOT_W-1:0];
            best = d;
            r.x = mirror_x[i];
            r.y = mirror_y[i];
            r.z = mirror_z[i];
         end
      end
      r.dist_sq = best[DIST_W-1:0];
      return r;
   endfunction

   // apply an accepted item to the mirror
   function automatic void absorb_item(tile_item_type it);
      if (it.op == nts_pkg::OP_WRITE) begin
         mirror_x[it.slot] = it.x;
         mirror_y[it.slot] = it.y;
         mirror_z[it.slot] = it.z;
      end else begin
         snap_expected.push_back(nearest_tile(it));
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at response %0d: %s", results_seen, what);
      mismatch_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_item(in_flight);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= in_flight.op;
               req_tdata <= REQ_W'({in_flight.z, in_flight.y, in_flight.x, in_flight.slot});
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_snap.x = rsp_tdata[COORD_W-1:0];
            seen_snap.y = rsp_tdata[2*COORD_W-1:COORD_W];
            seen_snap.z = rsp_tdata[3*COORD_W-1:2*COORD_W];
            seen_snap.slot = rsp_tdata[3*COORD_W+SLOT_W-1:3*COORD_W];
            seen_snap.dist_sq = rsp_tdata[3*COORD_W+SLOT_W+DIST_W-1:3*COORD_W+SLOT_W];
            seen_snap.found = rsp_tuser;
            if (snap_expected.size() == 0) begin
               report_mismatch("response with no query outstanding");
            end else begin
               due_snap = snap_expected.pop_front();
               if (seen_snap.x !== due_snap.x)
                  report_mismatch($sformatf("snap_x got %0d expected %0d",
                                            seen_snap.x, due_snap.x));
               if (seen_snap.y !== due_snap.y)
                  report_mismatch($sformatf("snap_y got %0d expected %0d",
                                            seen_snap.y, due_snap.y));
               if (seen_snap.z !== due_snap.z)
                  report_mismatch($sformatf("snap_z got %0d expected %0d",
                                            seen_snap.z, due_snap.z));
               if (seen_snap.found !== due_snap.found)
                  report_mismatch($sformatf("tile_found got %b expected %b",
                                            seen_snap.found, due_snap.found));
               if (seen_snap.slot !== due_snap.slot)
                  report_mismatch($sformatf("nearest_slot got %0d expected %0d",
                                            seen_snap.slot, due_snap.slot));
               if (seen_snap.dist_sq !== due_snap.dist_sq)
                  report_mismatch($sformatf("nearest_dist_sq got %0d expected %0d",
                                            seen_snap.dist_sq, due_snap.dist_sq));
            end
            results_seen++;
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // cycles since the last handshake on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAILURE");
      $finish;
   end

   function automatic coord_type rand_coord(int style);
      case (style)
         0: return coord_type'($urandom());
         1: return coord_type'(int'($urandom_range(8)) - 4);
         default: begin
            if ($urandom_range(1))
               return COORD_MAX - coord_type'($urandom_range(3));
            else
               return COORD_MIN + coord_type'($urandom_range(3));
         end
      endcase
   endfunction

   function automatic void queue_item(nts_pkg::opcode_type op, int unsigned slot,
                                      coord_type x, coord_type y, coord_type z);
      tile_item_type it;
      it.op = op;
      it.slot = slot[SLOT_W-1:0];
      it.x = x;
      it.y = y;
      it.z = z;
      if (op == nts_pkg::OP_WRITE) begin
         plan_x[it.slot] = x;
         plan_y[it.slot] = y;
         plan_z[it.slot] = z;
      end
      pending_items.push_back(it);
   endfunction

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || snap_expected.size() != 0)
         @(negedge clock);
   endtask

   // drain, write tile_count while idle, then pick the flow-control mix
   task automatic begin_phase(int unsigned count, int mode);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count[CNT_W-1:0];
      mirror_count = count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 69; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 69; end
         default: begin send_idle_pct = 35; rsp_stall_pct = 35; end
      endcase
   endtask

   // main sequence
   initial begin
      int unsigned count;
      int unsigned span;
      int unsigned slot;
      int          style;
      int          p;
      int          k;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table: the query point comes back with found clear
      begin_phase(0, 0);
      queue_item(nts_pkg::OP_QUERY, 1023, COORD_MIN, COORD_MAX, 0);
      queue_item(nts_pkg::OP_QUERY, 0, 0, 0, 0);
      queue_item(nts_pkg::OP_WRITE, 0, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_item(nts_pkg::OP_WRITE, 1, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_item(nts_pkg::OP_WRITE, 2, 100, -200, 300);
      queue_item(nts_pkg::OP_WRITE, 3, 100, -200, 300);
      queue_item(nts_pkg::OP_WRITE, 1023, -1, 0, 1);
      queue_item(nts_pkg::OP_QUERY, 512, -1, -1, -1);

      // one slot: largest distance and exact hit
      begin_phase(1, 0);
      queue_item(nts_pkg::OP_QUERY, 0, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_item(nts_pkg::OP_QUERY, 0, COORD_MAX, COORD_MAX, COORD_MAX);

      // four slots with a duplicated center, so ties go to the lower slot
      begin_phase(4, 0);
      queue_item(nts_pkg::OP_QUERY, 3, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_item(nts_pkg::OP_QUERY, 0, 100, -200, 300);
      queue_item(nts_pkg::OP_QUERY, 0, 101, -200, 300);
      queue_item(nts_pkg::OP_QUERY, 0, 0, 0, 0);
      queue_item(nts_pkg::OP_WRITE, 2, 7, 7, 7);
      queue_item(nts_pkg::OP_QUERY, 0, 7, 7, 6);
      queue_item(nts_pkg::OP_QUERY, 0, COORD_MAX, COORD_MIN, 0);

      // fill the low slots so that any count up to the fill may be scanned
      begin_phase(0, 1);
      for (k = 0; k < FILL_SLOTS; k++) begin
         style = $urandom_range(2);
         queue_item(nts_pkg::OP_WRITE, k, rand_coord(style), rand_coord(style),
                    rand_coord(style));
      end

      // randomized phases, mostly short scans, one over the whole fill and two long ones below it
      for (p = 0; p < 14; p++) begin
         case (p)
            0:  count = 0;
            3:  count = FILL_SLOTS;
            7:  count = FILL_SLOTS - 1;
            11: count = FILL_SLOTS / 2;
            default: count = $urandom_range(32, 1);
         endcase
         span = count;
         begin_phase(count, p % 4);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < 40) begin
               if (span > 0 && $urandom_range(9) < 7)
                  slot = $urandom_range(span - 1);
               else
                  slot = $urandom_range(TILES - 1);
               style = $urandom_range(2);
               queue_item(nts_pkg::OP_WRITE, slot, rand_coord(style), rand_coord(style),
                          rand_coord(style));
            end else begin
               style = $urandom_range(3);
               if (style == 3 && span > 0) begin
                  // aim exactly at a stored center
                  slot = $urandom_range(span - 1);
                  queue_item(nts_pkg::OP_QUERY, $urandom_range(TILES - 1),
                             plan_x[slot], plan_y[slot], plan_z[slot]);
               end else begin
                  style = style % 3;
                  queue_item(nts_pkg::OP_QUERY, $urandom_range(TILES - 1),
                             rand_coord(style), rand_coord(style), rand_coord(style));
               end
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
